### design/lbs_pkg.sv
// Package with the shared constants, command codes and types of the skinning core.
package lbs_pkg;

    localparam int DefMaxBones = 256;
    localparam int DefFracBits = 16;
    localparam int WeightBits  = 16;
    localparam int PosWords    = 12;
    localparam int RotWords    = 9;

    localparam logic [2:0] CMD_LOAD_POS = 3'd0;
    localparam logic [2:0] CMD_LOAD_ROT = 3'd1;
    localparam logic [2:0] CMD_SKIN_POS = 3'd2;
    localparam logic [2:0] CMD_SKIN_ROT = 3'd3;
    localparam logic [2:0] CMD_REPORT   = 3'd4;

    localparam logic [1:0] KIND_POS  = 2'd0;
    localparam logic [1:0] KIND_BASIS = 2'd1;
    localparam logic [1:0] KIND_MIN  = 2'd2;
    localparam logic [1:0] KIND_MAX  = 2'd3;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         command;
        logic [7:0]         bone_index;
        logic [3:0]         element_index;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [16:0]        weight0;
        logic [16:0]        weight1;
        logic [16:0]        weight2;
        logic [23:0]        packed_bones;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               degenerate;
        logic               last;
    } t_out_item;

    // Saturate a wide signed value into 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        logic signed [31:0] r;
        if (v > 96'sh7FFF_FFFF) r = Q_MAX;
        else if (v < -96'sh8000_0000) r = Q_MIN;
        else r = v[31:0];
        return r;
    endfunction

endpackage

### design/lbs_if.sv
// Valid/ready channel interfaces for the input and result items.
interface lbs_in_if;
    logic valid;
    logic ready;
    lbs_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lbs_out_if;
    logic valid;
    logic ready;
    lbs_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/linear_blend_skinning_core.sv
// Top level of the three-bone linear blend skinning core.
// Items enter a two-entry queue and are carried out one at a time by a shared
// sequencer that reads one palette word and forms one product in states S_RD,
// S_MUL and S_ROW. A skinned position runs three bones by three rows, each row four
// words and one weight step, then a blend and an output state. A basis vector runs
// the same row work with three words per row, a blend, a length sum, a square root
// after up to 31 normalizing shifts and a 96-bit restoring division for each of
// the three components; a zero vector skips root and division. Loads are written
// to the palettes as they leave the queue, and a report gives its two results on
// consecutive cycles while the receiver is ready. The palettes need no clearing
// after reset.
module linear_blend_skinning_core #(
    parameter int MAX_BONES = lbs_pkg::DefMaxBones,
    parameter int FRAC_BITS = lbs_pkg::DefFracBits
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lbs_in_if.sink    i_in,
    lbs_out_if.source o_out
);
    import lbs_pkg::*;

    t_in_item item;
    logic     valid, pop;

    lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
        .i_clk, .i_rst_n, .i_in, .o_item(item), .o_valid(valid), .i_pop(pop)
    );

    lbs_back #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_item(item), .i_valid(valid), .o_pop(pop), .o_out
    );
endmodule

### design/lbs_front.sv
// Front end: accepts items, drops loads and unknown commands it must ignore, queues the rest.
module lbs_front #(
    parameter int MAX_BONES = lbs_pkg::DefMaxBones
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lbs_in_if.sink           i_in,
    output lbs_pkg::t_in_item o_item,
    output logic             o_valid,
    input  logic             i_pop
);
    import lbs_pkg::*;

    localparam int Depth = 2;

    t_in_item   r_q [Depth];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       keep;
    logic       push;

    always_comb begin
        case (i_in.data.command)
            CMD_LOAD_POS: keep = (32'(i_in.data.bone_index) < MAX_BONES)
                                 && (i_in.data.element_index < 4'(PosWords));
            CMD_LOAD_ROT: keep = (32'(i_in.data.bone_index) < MAX_BONES)
                                 && (i_in.data.element_index < 4'(RotWords));
            CMD_SKIN_POS, CMD_SKIN_ROT, CMD_REPORT: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign i_in.ready = (r_cnt != 2'(Depth));
    assign push       = i_in.valid && i_in.ready && keep;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_in.data;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop && o_valid) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop && o_valid);
        end
    end
endmodule

### design/lbs_back.sv
// Back end: palettes, row transform sequencer, blend, bounds and the normalizer.
module lbs_back #(
    parameter int MAX_BONES = lbs_pkg::DefMaxBones,
    parameter int FRAC_BITS = lbs_pkg::DefFracBits
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbs_pkg::t_in_item i_item,
    input  logic              i_valid,
    output logic              o_pop,
    lbs_out_if.source         o_out
);
    import lbs_pkg::*;

    localparam int PosDepth = MAX_BONES * PosWords;
    localparam int RotDepth = MAX_BONES * RotWords;
    localparam int PaW = $clog2(PosDepth);
    localparam int RaW = $clog2(RotDepth);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ROW   = 4'd3;
    localparam logic [3:0] S_WMUL  = 4'd4;
    localparam logic [3:0] S_BLEND = 4'd5;
    localparam logic [3:0] S_LEN   = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_OUT2  = 4'd10;

    logic signed [31:0] r_pos_mem [PosDepth];
    logic signed [31:0] r_rot_mem [RotDepth];
    logic signed [31:0] r_rd;

    logic [3:0]  r_state;
    t_in_item    r_it;
    logic [1:0]  r_bone, r_row, r_col;
    logic        r_bone_ok;
    logic signed [95:0] r_rowacc;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_t;
    logic signed [95:0] r_acc [3];
    logic signed [31:0] r_res [3];
    logic signed [31:0] r_bmin [3];
    logic signed [31:0] r_bmax [3];
    logic [65:0] r_len;
    logic [5:0]  r_e;
    logic [63:0] r_v, r_sq, r_bit;
    logic [1:0]  r_dc;
    logic [6:0]  r_dstep;
    logic [95:0] r_num;
    logic [64:0] r_rem;
    logic [95:0] r_quo;
    logic        r_degen;
    logic        r_ovalid;
    t_out_item   r_odata;

    logic [7:0]  cur_bone;
    logic [1:0]  ncols;
    logic [PaW-1:0] pa, pwa;
    logic [RaW-1:0] ra, rwa;
    logic signed [31:0] vsel;
    logic signed [95:0] rowsum, rnd;
    logic [31:0] abs_c;
    logic [63:0] sq_term;
    logic [63:0] sq_v;
    logic [16:0] wsel;
    logic signed [49:0] wprod;
    logic        ovalid_set;

    function automatic logic [32:0] abs_c1(input logic signed [31:0] c);
        return c[31] ? 33'(-34'(c)) : 33'(c);
    endfunction

    assign cur_bone = r_it.packed_bones[8*r_bone +: 8];
    assign ncols = (r_it.command == CMD_SKIN_POS) ? 2'd3 : 2'd2;
    assign pa  = PaW'(32'(cur_bone) * PosWords + 32'(r_row) * 4 + 32'(r_col));
    assign ra  = RaW'(32'(cur_bone) * RotWords + 32'(r_row) * 3 + 32'(r_col));
    assign pwa = PaW'(32'(i_item.bone_index) * PosWords + 32'(i_item.element_index));
    assign rwa = RaW'(32'(i_item.bone_index) * RotWords + 32'(i_item.element_index));

    always_comb begin
        case (r_col)
            2'd0: vsel = r_it.x;
            2'd1: vsel = r_it.y;
            default: vsel = r_it.z;
        endcase
    end

    assign o_pop = (r_state == S_IDLE) && i_valid
                   && (i_item.command != CMD_REPORT || !r_ovalid);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // Rounded row value with the row's running sum.
    assign rowsum = r_rowacc + 96'(r_prod);
    assign rnd = (rowsum + (96'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign abs_c = 32'(abs_c1(r_res[r_dc]));
    assign sq_term = abs_c * abs_c;
    // The first root step works on the normalized length itself.
    assign sq_v = (r_bit == 64'd1 << 62) ? r_len[63:0] : r_v;
    assign wsel = (r_bone == 2'd0) ? r_it.weight0 :
                  (r_bone == 2'd1) ? r_it.weight1 : r_it.weight2;
    assign wprod = $signed({1'b0, wsel}) * r_t;

    assign ovalid_set = (o_pop && i_item.command == CMD_REPORT)
                        || (r_state == S_OUT && !r_ovalid)
                        || (r_state == S_OUT2 && (!r_ovalid || o_out.ready));

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.command == CMD_LOAD_POS) r_pos_mem[pwa] <= i_item.x;
        if (o_pop && i_item.command == CMD_LOAD_ROT) r_rot_mem[rwa] <= i_item.x;
        r_rd <= (r_it.command == CMD_SKIN_POS) ? r_pos_mem[pa] : r_rot_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (ovalid_set) r_ovalid <= 1'b1;
        else if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            for (int i = 0; i < 3; i++) begin
                r_bmin[i] <= Q_MAX;
                r_bmax[i] <= Q_MIN;
            end
        end else begin
            case (r_state)
                S_IDLE: if (o_pop) begin
                    r_it <= i_item;
                    r_bone <= '0; r_row <= '0; r_col <= '0;
                    r_rowacc <= '0; r_prod <= '0;
                    for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                    case (i_item.command)
                        CMD_SKIN_POS, CMD_SKIN_ROT: r_state <= S_RD;
                        CMD_REPORT: begin
                            r_odata <= '{KIND_MIN, r_bmin[0], r_bmin[1], r_bmin[2],
                                         1'b0, 1'b0};
                            r_state <= S_OUT2;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_RD: begin
                    r_bone_ok <= 32'(cur_bone) < MAX_BONES;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // Fourth column of a position row is the translation word.
                    if (r_col == 2'd3)
                        r_prod <= r_bone_ok ? (64'(r_rd) <<< FRAC_BITS) : '0;
                    else
                        r_prod <= r_bone_ok ? 64'(r_rd) * 64'(vsel) : '0;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    if (r_col == ncols) begin
                        r_t <= sat32(rnd);
                        r_rowacc <= '0;
                        r_state <= S_WMUL;
                    end else begin
                        r_rowacc <= rowsum;
                        r_col <= r_col + 2'd1;
                        r_state <= S_RD;
                    end
                    r_prod <= '0;
                end
                S_WMUL: begin
                    r_acc[r_row] <= r_acc[r_row] + 96'(wprod);
                    r_col <= '0;
                    if (r_row == 2'd2) begin
                        r_row <= '0;
                        if (r_bone == 2'd2) r_state <= S_BLEND;
                        else begin
                            r_bone <= r_bone + 2'd1;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_row <= r_row + 2'd1;
                        r_state <= S_RD;
                    end
                end
                S_BLEND: begin
                    for (int i = 0; i < 3; i++)
                        r_res[i] <= sat32((r_acc[i] + (96'sd1 <<< (WeightBits - 1)))
                                          >>> WeightBits);
                    r_len <= '0; r_dc <= '0;
                    r_state <= (r_it.command == CMD_SKIN_POS) ? S_OUT : S_LEN;
                end
                S_LEN: begin
                    // One square per cycle into the length accumulator.
                    r_len <= r_len + 66'(sq_term);
                    if (r_dc == 2'd2) begin
                        r_dc <= '0; r_e <= '0;
                        r_state <= S_SQRT;
                        r_bit <= 64'd1 << 62; r_sq <= '0;
                    end else r_dc <= r_dc + 2'd1;
                end
                S_SQRT: begin
                    if (r_len == 66'd0) begin
                        r_degen <= 1'b1;
                        for (int i = 0; i < 3; i++) r_res[i] <= '0;
                        r_state <= S_OUT;
                    end else if (r_len[63:62] == 2'b00) begin
                        r_len <= r_len << 2;
                        r_e <= r_e + 6'd1;
                    end else if (r_bit != 64'd0) begin
                        if (sq_v >= r_sq + r_bit) begin
                            r_v <= sq_v - (r_sq + r_bit);
                            r_sq <= (r_sq >> 1) + r_bit;
                        end else begin
                            r_v <= sq_v;
                            r_sq <= r_sq >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_degen <= 1'b0;
                        r_dc <= '0;
                        r_num <= 96'(abs_c) << (32'(r_e) + FRAC_BITS);
                        r_rem <= '0; r_quo <= '0; r_dstep <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    logic [64:0] t;
                    logic        qb;
                    logic [95:0] q;
                    t  = {r_rem[63:0], r_num[95 - 32'(r_dstep)]};
                    qb = (t >= 65'(r_sq));
                    q  = {r_quo[94:0], qb};
                    if (r_dstep == 7'd95) begin
                        r_dstep <= '0;
                        r_rem <= '0;
                        r_quo <= '0;
                        r_res[r_dc] <= sat32(r_res[r_dc][31] ? -$signed(q) : $signed(q));
                        if (r_dc == 2'd2) r_state <= S_OUT;
                        else begin
                            r_dc <= r_dc + 2'd1;
                            r_num <= 96'(abs_c1(r_res[r_dc + 2'd1])) << (32'(r_e) + FRAC_BITS);
                        end
                    end else begin
                        r_dstep <= r_dstep + 7'd1;
                        r_rem <= qb ? t - 65'(r_sq) : t;
                        r_quo <= q;
                    end
                end
                S_OUT: if (!r_ovalid) begin
                    if (r_it.command == CMD_SKIN_POS) begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_res[i] < r_bmin[i]) r_bmin[i] <= r_res[i];
                            if (r_res[i] > r_bmax[i]) r_bmax[i] <= r_res[i];
                        end
                        r_odata <= '{KIND_POS, r_res[0], r_res[1], r_res[2], 1'b0, 1'b1};
                    end else
                        r_odata <= '{KIND_BASIS, r_res[0], r_res[1], r_res[2],
                                     r_degen, 1'b1};
                    r_state <= S_IDLE;
                end
                S_OUT2: if (!r_ovalid || o_out.ready) begin
                    r_odata <= '{KIND_MAX, r_bmax[0], r_bmax[1], r_bmax[2], 1'b0, 1'b1};
                    for (int i = 0; i < 3; i++) begin
                        r_bmin[i] <= Q_MAX;
                        r_bmax[i] <= Q_MIN;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### design/lbs_checker.sv
// Port checker for the skinning core and its bind.
module lbs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] kind,
    input logic last,
    input logic degenerate
);
    import lbs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_min_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && kind == KIND_MIN |-> !last) else $error("minimum marked last");
    a_max_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && kind != KIND_MIN |-> last) else $error("last missing");
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && degenerate |-> kind == KIND_BASIS) else $error("bad degenerate");
endmodule

bind linear_blend_skinning_core lbs_checker u_chk (
    .i_clk, .i_rst_n, .out_valid(o_out.valid), .out_ready(o_out.ready),
    .kind(o_out.data.result_kind), .last(o_out.data.last),
    .degenerate(o_out.data.degenerate)
);

### dv/linear_blend_skinning_core_tb.sv
// Testbench for the skinning core: random and directed items checked against a predictor.
module linear_blend_skinning_core_tb;
    import lbs_pkg::*;

    localparam int NUM_BONES = 256;
    localparam int FB = 16;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic i_clk;
    logic i_rst_n;
    lbs_in_if in_ch();
    lbs_out_if out_ch();

    linear_blend_skinning_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    // Skinning predictor with its own palettes and box.
    class skin_scoreboard;
        logic signed [31:0] pos_pal[NUM_BONES*12];
        logic signed [31:0] rot_pal[NUM_BONES*9];
        logic signed [31:0] box_lo[3];
        logic signed [31:0] box_hi[3];
        t_out_item pending[$];
        int errors;

        function new();
            foreach (pos_pal[i]) pos_pal[i] = '0;
            foreach (rot_pal[i]) rot_pal[i] = '0;
            clear_box();
            errors = 0;
        endfunction

        function void clear_box();
            for (int i = 0; i < 3; i++) begin
                box_lo[i] = Q_MAX;
                box_hi[i] = Q_MIN;
            end
        endfunction

        function logic signed [31:0] clamp32(logic signed [127:0] v);
            if (v > 128'sh7FFF_FFFF) return Q_MAX;
            if (v < -128'sh8000_0000) return Q_MIN;
            return v[31:0];
        endfunction

        // One matrix row times the vector, plus a translation when given, rounded.
        function logic signed [31:0] row_xform(logic signed [31:0] m0, logic signed [31:0] m1,
                logic signed [31:0] m2, logic signed [31:0] t, logic signed [31:0] vx,
                logic signed [31:0] vy, logic signed [31:0] vz);
            logic signed [127:0] s;
            s = 128'(m0) * 128'(vx) + 128'(m1) * 128'(vy) + 128'(m2) * 128'(vz)
                + (128'(t) <<< FB) + (128'sd1 <<< (FB - 1));
            return clamp32(s >>> FB);
        endfunction

        function void blend_bones(t_in_item it, bit rot, output logic signed [31:0] res[3]);
            logic signed [127:0] acc[3];
            logic signed [31:0] m[12];
            int bn;
            for (int r = 0; r < 3; r++) acc[r] = 0;
            for (int b = 0; b < 3; b++) begin
                bn = it.packed_bones[8*b +: 8];
                for (int k = 0; k < 12; k++) m[k] = 0;
                if (rot) for (int k = 0; k < 9; k++) m[k] = rot_pal[bn*9 + k];
                else for (int k = 0; k < 12; k++) m[k] = pos_pal[bn*12 + k];
                for (int r = 0; r < 3; r++) begin
                    logic signed [31:0] t;
                    if (rot) t = row_xform(m[r*3], m[r*3+1], m[r*3+2], 0, it.x, it.y, it.z);
                    else t = row_xform(m[r*4], m[r*4+1], m[r*4+2], m[r*4+3], it.x, it.y, it.z);
                    case (b)
                        0: acc[r] += 128'($signed({1'b0, it.weight0})) * 128'(t);
                        1: acc[r] += 128'($signed({1'b0, it.weight1})) * 128'(t);
                        default: acc[r] += 128'($signed({1'b0, it.weight2})) * 128'(t);
                    endcase
                end
            end
            for (int r = 0; r < 3; r++)
                res[r] = clamp32((acc[r] + (128'sd1 <<< (WeightBits - 1))) >>> WeightBits);
        endfunction

        function logic [63:0] root64(logic [63:0] v);
            logic [63:0] r, bt;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > v) bt >>= 2;
            while (bt != 0) begin
                if (v >= r + bt) begin
                    v -= r + bt;
                    r = (r >> 1) + bt;
                end else r >>= 1;
                bt >>= 2;
            end
            return r;
        endfunction

        function void note_input(t_in_item it);
            logic signed [31:0] v[3];
            t_out_item o;
            o = '0;
            case (it.command)
                CMD_LOAD_POS: if (it.element_index < 12) pos_pal[it.bone_index*12 +
                    it.element_index] = it.x;
                CMD_LOAD_ROT: if (it.element_index < 9) rot_pal[it.bone_index*9 +
                    it.element_index] = it.x;
                CMD_SKIN_POS: begin
                    blend_bones(it, 0, v);
                    for (int i = 0; i < 3; i++) begin
                        if (v[i] < box_lo[i]) box_lo[i] = v[i];
                        if (v[i] > box_hi[i]) box_hi[i] = v[i];
                    end
                    o.result_kind = KIND_POS;
                    o.out_x = v[0]; o.out_y = v[1]; o.out_z = v[2]; o.last = 1;
                    pending.push_back(o);
                end
                CMD_SKIN_ROT: begin
                    logic [63:0] len, rt, a;
                    logic [127:0] q;
                    int e;
                    blend_bones(it, 1, v);
                    len = 0;
                    for (int i = 0; i < 3; i++) begin
                        a = v[i] < 0 ? 64'(-64'(v[i])) : 64'(v[i]);
                        len += a * a;
                    end
                    o.result_kind = KIND_BASIS;
                    o.last = 1;
                    if (len == 0) o.degenerate = 1;
                    else begin
                        e = 0;
                        while (len[63:62] == 0) begin
                            len <<= 2;
                            e++;
                        end
                        rt = root64(len);
                        for (int i = 0; i < 3; i++) begin
                            a = v[i] < 0 ? 64'(-64'(v[i])) : 64'(v[i]);
                            q = ((128'(a) << e) << FB) / 128'(rt);
                            q = q[63:0];
                            v[i] = v[i] < 0 ? clamp32(-$signed(q)) : clamp32($signed(q));
                        end
                        o.out_x = v[0]; o.out_y = v[1]; o.out_z = v[2];
                    end
                    pending.push_back(o);
                end
                CMD_REPORT: begin
                    o.result_kind = KIND_MIN;
                    o.out_x = box_lo[0]; o.out_y = box_lo[1]; o.out_z = box_lo[2];
                    pending.push_back(o);
                    o.result_kind = KIND_MAX;
                    o.out_x = box_hi[0]; o.out_y = box_hi[1]; o.out_z = box_hi[2];
                    o.last = 1;
                    pending.push_back(o);
                    clear_box();
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected kind=%0d x=%h y=%h z=%h deg=%b last=%b",
                    $time, want.result_kind, want.out_x, want.out_y, want.out_z,
                    want.degenerate, want.last);
                $display("%0t:          actual   kind=%0d x=%h y=%h z=%h deg=%b last=%b",
                    $time, got.result_kind, got.out_x, got.out_y, got.out_z,
                    got.degenerate, got.last);
                errors++;
            end
        endfunction
    endclass

    skin_scoreboard sb;
    bit quiet_phase;
    bit hold_off;
    bit written_pos[NUM_BONES];
    bit written_rot[NUM_BONES];
    longint cycles;
    int stall_left;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("linear_blend_skinning_core verification failed");
                $finish;
            end
        end
    end

    // Result side: random stall bursts and one long hold-off.
    initial begin
        out_ch.ready = 0;
        stall_left = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
            if (hold_off) out_ch.ready <= 0;
            else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                out_ch.ready <= 0;
            end else out_ch.ready <= 1;
        end
    end

    task automatic send_item(t_in_item it);
        in_ch.valid <= 1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(it);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return $signed(32'($urandom_range(0, 32'h3_0000))) - 32'sh1_8000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 4))
            0: return 17'd65536;
            1: return 17'd0;
            2: return 17'($urandom());
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Pick a bone whose matrix was fully loaded.
    function automatic logic [7:0] pick_bone(bit rot);
        int b;
        do b = $urandom_range(0, NUM_BONES - 1); while (rot ? !written_rot[b] : !written_pos[b]);
        return 8'(b);
    endfunction

    task automatic load_bone(bit rot, int b, bit unit);
        t_in_item it;
        it = '0;
        for (int k = 0; k < (rot ? 9 : 12); k++) begin
            it.command = rot ? CMD_LOAD_ROT : CMD_LOAD_POS;
            it.bone_index = 8'(b);
            it.element_index = 4'(k);
            if (unit) it.x = ((rot && k % 4 == 0) || (!rot && k % 5 == 0)) ? 32'sh1_0000 : 0;
            else it.x = rand_word();
            send_item(it);
        end
        if (rot) written_rot[b] = 1; else written_pos[b] = 1;
    endtask

    task automatic skin_item(logic [2:0] cmd);
        t_in_item it;
        bit rot;
        it = '0;
        rot = (cmd == CMD_SKIN_ROT);
        it.command = cmd;
        it.bone_index = 8'($urandom());
        it.element_index = 4'($urandom());
        it.x = rand_word(); it.y = rand_word(); it.z = rand_word();
        if ($urandom_range(0, 7) == 0) begin
            it.x = 0; it.y = 0; it.z = 0;
        end
        it.weight0 = rand_weight(); it.weight1 = rand_weight(); it.weight2 = rand_weight();
        it.packed_bones = {pick_bone(rot), pick_bone(rot), pick_bone(rot)};
        send_item(it);
    endtask

    initial begin
        t_in_item it;
        sb = new();
        quiet_phase = 0;
        hold_off = 0;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty report, identity and extreme bones, ignored items.
        it = '0; it.command = CMD_REPORT; send_item(it);
        load_bone(0, 0, 1); load_bone(1, 0, 1);
        load_bone(0, 255, 0); load_bone(1, 255, 0);
        it = '0; it.command = CMD_LOAD_POS; it.element_index = 4'd15; it.x = Q_MAX;
        send_item(it);
        it.command = CMD_LOAD_ROT; it.element_index = 4'd9; send_item(it);
        it.command = 3'd5; send_item(it);
        it.command = 3'd7; it.bone_index = 8'hFF; send_item(it);
        it = '0; it.command = CMD_SKIN_POS; it.x = Q_MAX; it.y = Q_MIN; it.z = -1;
        it.weight0 = 17'd65536; it.weight1 = 17'h1FFFF; it.weight2 = 17'h1FFFF;
        it.packed_bones = 24'hFFFF00; send_item(it);
        it.command = CMD_SKIN_ROT; send_item(it);
        it.x = 0; it.y = 0; it.z = 0; send_item(it);
        it.x = 1; it.packed_bones = 24'd0; send_item(it);
        it = '0; it.command = CMD_REPORT; send_item(it);

        for (int i = 0; i < 8; i++) begin
            load_bone(0, $urandom_range(1, 254), 0);
            load_bone(1, $urandom_range(1, 254), 0);
        end

        // Long receiver hold-off while items keep coming.
        fork
            begin
                hold_off = 1;
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++) skin_item(CMD_SKIN_POS);
        join

        for (int i = 0; i < 270; i++) begin
            if (i == 200) quiet_phase = 1;
            case ($urandom_range(0, 9))
                0: load_bone(1'($urandom_range(0, 1)), $urandom_range(0, 255), 0);
                1: begin
                    it = '0; it.command = 3'($urandom_range(5, 7));
                    it.bone_index = 8'($urandom()); send_item(it);
                end
                2: begin
                    it = '0; it.command = CMD_REPORT; send_item(it);
                end
                3, 4, 5: skin_item(CMD_SKIN_ROT);
                default: skin_item(CMD_SKIN_POS);
            endcase
        end
        in_ch.valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0)
            $display("linear_blend_skinning_core verification clean");
        else
            $display("linear_blend_skinning_core verification failed");
        $finish;
    end
endmodule
